// File: design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Shared types, protocol constants and status codes of the ARP responder.
// ----------------------------------------------------------------------------
package arpc_pkg;

    typedef logic [31:0] t_ip;
    typedef logic [47:0] t_mac;
    typedef logic [2:0]  t_status;

    localparam logic [10:0] ARP_MIN_LEN  = 11'd28;
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [15:0] OPC_REQUEST  = 16'h0001;
    localparam logic [15:0] OPC_REPLY    = 16'h0002;

    localparam t_ip OWN_IP_RESET = 32'h0A00_020F;

    localparam t_status ST_ACCEPT = 3'd0;
    localparam t_status ST_REPLY  = 3'd1;
    localparam t_status ST_SHORT  = 3'd2;
    localparam t_status ST_BADHW  = 3'd3;
    localparam t_status ST_BADPRO = 3'd4;
    localparam t_status ST_BADOP  = 3'd5;
    localparam t_status ST_HIT    = 3'd6;
    localparam t_status ST_MISS   = 3'd7;

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    typedef struct packed {
        logic hit;
        t_ip  ip;
        t_mac mac;
    } t_token;

    typedef struct packed {
        logic en;
        logic fill;
        t_ip  ip;
        t_mac mac;
    } t_wr;

    typedef struct packed {
        t_status status;
        logic    send_reply;
        t_mac    reply_dest_mac;
        t_ip     reply_dst_ip;
        t_mac    reply_src_mac;
        t_ip     reply_src_ip;
        t_mac    found_mac;
    } t_rsp;

endpackage

// File: design/arpc_if.sv
// ----------------------------------------------------------------------------
// ARP responder channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface arpc_req_if;
    logic          valid;
    logic          ready;
    logic          op;
    logic [10:0]   frame_length;
    logic [15:0]   hardware_type;
    logic [15:0]   protocol_type;
    logic [15:0]   arp_opcode;
    arpc_pkg::t_ip  src_ip;
    arpc_pkg::t_mac src_mac;
    arpc_pkg::t_ip  dst_ip;
    arpc_pkg::t_ip  query_ip;

    modport source (
        output valid, op, frame_length, hardware_type, protocol_type, arp_opcode,
               src_ip, src_mac, dst_ip, query_ip,
        input  ready
    );
    modport sink (
        input  valid, op, frame_length, hardware_type, protocol_type, arp_opcode,
               src_ip, src_mac, dst_ip, query_ip,
        output ready
    );
endinterface

interface arpc_rsp_if;
    logic              valid;
    logic              ready;
    arpc_pkg::t_status status;
    logic              send_reply;
    arpc_pkg::t_mac    reply_dest_mac;
    arpc_pkg::t_ip     reply_dst_ip;
    arpc_pkg::t_mac    reply_src_mac;
    arpc_pkg::t_ip     reply_src_ip;
    arpc_pkg::t_mac    found_mac;

    modport source (
        output valid, status, send_reply, reply_dest_mac, reply_dst_ip,
               reply_src_mac, reply_src_ip, found_mac,
        input  ready
    );
    modport sink (
        input  valid, status, send_reply, reply_dest_mac, reply_dst_ip,
               reply_src_mac, reply_src_ip, found_mac,
        output ready
    );
endinterface

// File: design/arpc_cell.sv
// ----------------------------------------------------------------------------
// ARP cache cell
// Holds one cache entry and compares it against the search token passing by.
// ----------------------------------------------------------------------------
module arpc_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok_vld,
    input  arpc_pkg::t_token     i_tok,
    input  logic [IDX_W-1:0]     i_tok_idx,
    output logic                 o_tok_vld,
    output arpc_pkg::t_token     o_tok,
    output logic [IDX_W-1:0]     o_tok_idx,
    input  arpc_pkg::t_wr        i_wr,
    input  logic [IDX_W-1:0]     i_wr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic             r_valid;
    arpc_pkg::t_ip    r_ip;
    arpc_pkg::t_mac   r_mac;
    logic             r_tok_vld;
    arpc_pkg::t_token r_tok;
    logic [IDX_W-1:0] r_tok_idx;
    arpc_pkg::t_token n_tok;
    logic [IDX_W-1:0] n_tok_idx;
    logic             match;
    logic             wr_sel;

    assign match  = i_tok_vld && !i_tok.hit && r_valid && (r_ip == i_tok.ip);
    assign wr_sel = i_wr.en && (i_wr_idx == MY_IDX);

    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (match) begin
            n_tok.hit = 1'b1;
            n_tok.mac = r_mac;
            n_tok_idx = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
            if (wr_sel && i_wr.fill) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_tok_idx <= n_tok_idx;
        if (wr_sel) begin
            r_mac <= i_wr.mac;
            if (i_wr.fill) begin
                r_ip <= i_wr.ip;
            end
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

// File: design/arp_responder_with_cache.sv
// ----------------------------------------------------------------------------
// ARP responder with address cache
// Checks received ARP packets, learns sender mappings, builds reply fields
// and answers cache lookups.
// ----------------------------------------------------------------------------
// The block works on one item at a time: it accepts the item, the search token
// walks the row of cache cells, and then the block delivers the result and writes
// back the learned entry, once the output register is free. The next item is
// taken the cycle after, and a finished result waits in the output register
// until it is taken. Registers: own IP at address 0, own MAC at address 8, both
// 64-bit words. The cache needs no clearing pass.
module arp_responder_with_cache #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    arpc_req_if.sink     i_req,
    arpc_rsp_if.source   o_rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    arpc_pkg::t_ip       r_own_ip;
    arpc_pkg::t_mac      r_own_mac;
    logic                r_op;
    logic                r_learn;
    arpc_pkg::t_status   r_pre;
    arpc_pkg::t_ip       r_s_ip;
    arpc_pkg::t_mac      r_s_mac;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    arpc_pkg::t_mac      r_hit_mac;
    logic [IDX_W-1:0]    r_ptr;
    logic                r_out_vld;
    arpc_pkg::t_rsp      r_out;
    arpc_pkg::t_rsp      n_out;
    arpc_pkg::t_status   n_pre;
    logic                n_learn;
    logic                accept;
    logic                out_free;
    logic                finish;
    logic                cfg_wr;
    arpc_pkg::t_wr       w_wr;
    logic [IDX_W-1:0]    w_wr_idx;

    logic                w_vld [CACHE_ENTRIES+1];
    arpc_pkg::t_token    w_tok [CACHE_ENTRIES+1];
    logic [IDX_W-1:0]    w_idx [CACHE_ENTRIES+1];

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3])
            arpc_pkg::REG_OWN_IP:  prdata = {32'd0, r_own_ip};
            arpc_pkg::REG_OWN_MAC: prdata = {16'd0, r_own_mac};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= arpc_pkg::OWN_IP_RESET;
            r_own_mac <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                arpc_pkg::REG_OWN_IP:  r_own_ip  <= pwdata[31:0];
                arpc_pkg::REG_OWN_MAC: r_own_mac <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    // Packet checks at accept time.
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign finish      = (r_state == S_DONE) && out_free;

    always_comb begin
        n_learn = 1'b0;
        priority if (i_req.frame_length < arpc_pkg::ARP_MIN_LEN) begin
            n_pre = arpc_pkg::ST_SHORT;
        end else if (i_req.hardware_type != arpc_pkg::HW_ETHERNET) begin
            n_pre = arpc_pkg::ST_BADHW;
        end else if (i_req.protocol_type != arpc_pkg::PROTO_IPV4) begin
            n_pre = arpc_pkg::ST_BADPRO;
        end else begin
            n_learn = !i_req.op;
            priority if (i_req.arp_opcode == arpc_pkg::OPC_REQUEST) begin
                n_pre = (i_req.dst_ip == r_own_ip) ? arpc_pkg::ST_REPLY
                                                   : arpc_pkg::ST_ACCEPT;
            end else if (i_req.arp_opcode == arpc_pkg::OPC_REPLY) begin
                n_pre = arpc_pkg::ST_ACCEPT;
            end else begin
                n_pre = arpc_pkg::ST_BADOP;
            end
        end
    end

    // Row of cache cells.
    assign w_vld[0]     = accept;
    assign w_tok[0].hit = 1'b0;
    assign w_tok[0].ip  = i_req.op ? i_req.query_ip : i_req.src_ip;
    assign w_tok[0].mac = '0;
    assign w_idx[0]     = '0;

    assign w_wr.en   = finish && r_learn;
    assign w_wr.fill = !r_hit;
    assign w_wr.ip   = r_s_ip;
    assign w_wr.mac  = r_s_mac;
    assign w_wr_idx  = r_hit ? r_hit_idx : r_ptr;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        arpc_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok_vld (w_vld[g]),
            .i_tok     (w_tok[g]),
            .i_tok_idx (w_idx[g]),
            .o_tok_vld (w_vld[g+1]),
            .o_tok     (w_tok[g+1]),
            .o_tok_idx (w_idx[g+1]),
            .i_wr      (w_wr),
            .i_wr_idx  (w_wr_idx)
        );
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept) n_state = S_SCAN;
            S_SCAN:  if (w_vld[CACHE_ENTRIES]) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr.en && w_wr.fill) begin
                r_ptr <= (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            end
            if (finish) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_req.op;
            r_learn <= n_learn;
            r_pre   <= n_pre;
            r_s_ip  <= i_req.src_ip;
            r_s_mac <= i_req.src_mac;
        end
        if ((r_state == S_SCAN) && w_vld[CACHE_ENTRIES]) begin
            r_hit     <= w_tok[CACHE_ENTRIES].hit;
            r_hit_idx <= w_idx[CACHE_ENTRIES];
            r_hit_mac <= w_tok[CACHE_ENTRIES].mac;
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    // Result assembly.
    always_comb begin
        n_out = '0;
        if (r_op) begin
            n_out.status    = r_hit ? arpc_pkg::ST_HIT : arpc_pkg::ST_MISS;
            n_out.found_mac = r_hit ? r_hit_mac : '0;
        end else begin
            n_out.status = r_pre;
            if (r_pre == arpc_pkg::ST_REPLY) begin
                n_out.send_reply     = 1'b1;
                n_out.reply_dest_mac = r_s_mac;
                n_out.reply_dst_ip   = r_s_ip;
                n_out.reply_src_mac  = r_own_mac;
                n_out.reply_src_ip   = r_own_ip;
            end
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.send_reply     = r_out.send_reply;
    assign o_rsp.reply_dest_mac = r_out.reply_dest_mac;
    assign o_rsp.reply_dst_ip   = r_out.reply_dst_ip;
    assign o_rsp.reply_src_mac  = r_out.reply_src_mac;
    assign o_rsp.reply_src_ip   = r_out.reply_src_ip;
    assign o_rsp.found_mac      = r_out.found_mac;

endmodule

// File: design/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP responder checker
// Port-level assertions on the ARP responder, attached by a bind statement.
// ----------------------------------------------------------------------------
module arpc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input arpc_pkg::t_status i_rsp_status,
    input logic              i_rsp_send_reply,
    input arpc_pkg::t_mac    i_rsp_found_mac
);

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result item dropped while stalled");

    // A stalled result keeps its status.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_status))
        else $error("result status changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second item taken while busy");

    // A reply is only requested with the reply status.
    a_reply_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_send_reply |-> i_rsp_status == arpc_pkg::ST_REPLY)
        else $error("reply flagged without reply status");

    // The found address is zero unless a lookup hit.
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != arpc_pkg::ST_HIT) |-> i_rsp_found_mac == '0)
        else $error("found address set without a hit");

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_send_reply (o_rsp.send_reply),
    .i_rsp_found_mac  (o_rsp.found_mac)
);

// File: bench/arp_responder_with_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder with cache testbench
// Sends received ARP packets and cache lookups through the input channel,
// predicts every result with a model of the cache and the reply rules, and
// compares each result item field by field under random gaps and stalls.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_tb;

    localparam int CLK_PERIOD    = 10;
    localparam int CACHE_ENTRIES = 16;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int PHASES        = 4;
    localparam int HOLD_AT_ITEM  = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IP_POOL_SIZE  = 24;

    localparam logic [3:0] ADDR_OWN_IP  = {arpc_pkg::REG_OWN_IP, 3'b000};
    localparam logic [3:0] ADDR_OWN_MAC = {arpc_pkg::REG_OWN_MAC, 3'b000};

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct {
        logic           op;
        logic [10:0]    frame_length;
        logic [15:0]    hardware_type;
        logic [15:0]    protocol_type;
        logic [15:0]    arp_opcode;
        arpc_pkg::t_ip  src_ip;
        arpc_pkg::t_mac src_mac;
        arpc_pkg::t_ip  dst_ip;
        arpc_pkg::t_ip  query_ip;
    } t_arp_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    arpc_req_if arp_req ();
    arpc_rsp_if arp_rsp ();

    t_arp_item      arp_pending[$];
    t_arp_item      arp_current;
    arpc_pkg::t_rsp rsp_expected[$];
    arpc_pkg::t_rsp rsp_want;
    arpc_pkg::t_ip  ip_pool[IP_POOL_SIZE];

    arpc_pkg::t_ip  own_ip_model = arpc_pkg::OWN_IP_RESET;
    arpc_pkg::t_mac own_mac_model = '0;
    arpc_pkg::t_ip  cache_ip[CACHE_ENTRIES];
    arpc_pkg::t_mac cache_mac[CACHE_ENTRIES];
    logic           cache_valid[CACHE_ENTRIES] = '{default: 1'b0};
    int             cache_next = 0;

    int   items_accepted = 0;
    int   errors = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   send_gap = 0;
    int   send_burst = 0;
    int   recv_stall = 0;
    int   recv_burst = 0;

    arp_responder_with_cache #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arp_req),
        .o_rsp   (arp_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic arpc_pkg::t_mac rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic arpc_pkg::t_ip pick_ip();
        if ($urandom_range(9) == 0) begin
            return $urandom;
        end
        return ip_pool[$urandom_range(IP_POOL_SIZE - 1)];
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(ref int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            burst = $urandom_range(40, 15);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    function automatic int cache_find(arpc_pkg::t_ip ip);
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (cache_valid[i] && cache_ip[i] == ip) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Works out the result of one accepted item and updates the cache copy.
    function automatic arpc_pkg::t_rsp resolve_arp_item(t_arp_item it);
        arpc_pkg::t_rsp rsp;
        int             slot;
        rsp = '0;
        if (it.op == OP_LOOKUP) begin
            slot = cache_find(it.query_ip);
            if (slot >= 0) begin
                rsp.status = arpc_pkg::ST_HIT;
                rsp.found_mac = cache_mac[slot];
            end else begin
                rsp.status = arpc_pkg::ST_MISS;
            end
        end else if (it.frame_length < arpc_pkg::ARP_MIN_LEN) begin
            rsp.status = arpc_pkg::ST_SHORT;
        end else if (it.hardware_type != arpc_pkg::HW_ETHERNET) begin
            rsp.status = arpc_pkg::ST_BADHW;
        end else if (it.protocol_type != arpc_pkg::PROTO_IPV4) begin
            rsp.status = arpc_pkg::ST_BADPRO;
        end else begin
            slot = cache_find(it.src_ip);
            if (slot >= 0) begin
                cache_mac[slot] = it.src_mac;
            end else begin
                cache_ip[cache_next] = it.src_ip;
                cache_mac[cache_next] = it.src_mac;
                cache_valid[cache_next] = 1'b1;
                cache_next = (cache_next + 1) % CACHE_ENTRIES;
            end
            if (it.arp_opcode == arpc_pkg::OPC_REQUEST) begin
                if (it.dst_ip == own_ip_model) begin
                    rsp.status = arpc_pkg::ST_REPLY;
                    rsp.send_reply = 1'b1;
                    rsp.reply_dest_mac = it.src_mac;
                    rsp.reply_dst_ip = it.src_ip;
                    rsp.reply_src_mac = own_mac_model;
                    rsp.reply_src_ip = own_ip_model;
                end else begin
                    rsp.status = arpc_pkg::ST_ACCEPT;
                end
            end else if (it.arp_opcode == arpc_pkg::OPC_REPLY) begin
                rsp.status = arpc_pkg::ST_ACCEPT;
            end else begin
                rsp.status = arpc_pkg::ST_BADOP;
            end
        end
        return rsp;
    endfunction

    // Fields that the item's operation does not use are random throughout.
    function automatic t_arp_item noise_item();
        t_arp_item it;
        it.op = OP_LOOKUP;
        it.frame_length = 11'($urandom);
        it.hardware_type = 16'($urandom);
        it.protocol_type = 16'($urandom);
        it.arp_opcode = 16'($urandom);
        it.src_ip = $urandom;
        it.src_mac = rand_mac();
        it.dst_ip = $urandom;
        it.query_ip = $urandom;
        return it;
    endfunction

    function automatic t_arp_item random_arp_item();
        t_arp_item it;
        int        r;
        it = noise_item();
        r = $urandom_range(99);
        if (r < 30) begin
            it.query_ip = pick_ip();
            return it;
        end
        it.op = OP_PACKET;
        it.frame_length = ($urandom_range(3) == 0) ? 11'($urandom_range(2047, 28))
                                                   : 11'($urandom_range(60, 28));
        it.hardware_type = arpc_pkg::HW_ETHERNET;
        it.protocol_type = arpc_pkg::PROTO_IPV4;
        it.src_ip = pick_ip();
        it.dst_ip = $urandom_range(1) ? own_ip_model : pick_ip();
        r = $urandom_range(99);
        if (r < 50) begin
            it.arp_opcode = arpc_pkg::OPC_REQUEST;
        end else if (r < 88) begin
            it.arp_opcode = arpc_pkg::OPC_REPLY;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            it.frame_length = 11'($urandom_range(27));
        end else if (r < 8) begin
            it.hardware_type = 16'($urandom);
        end else if (r < 12) begin
            it.protocol_type = 16'($urandom);
        end else if (r < 15) begin
            it.frame_length = 11'($urandom);
        end
        return it;
    endfunction

    task automatic queue_packet(logic [10:0] len, logic [15:0] hw, logic [15:0] proto,
                                logic [15:0] opc, arpc_pkg::t_ip sip,
                                arpc_pkg::t_mac smac, arpc_pkg::t_ip tip);
        t_arp_item it;
        it = noise_item();
        it.op = OP_PACKET;
        it.frame_length = len;
        it.hardware_type = hw;
        it.protocol_type = proto;
        it.arp_opcode = opc;
        it.src_ip = sip;
        it.src_mac = smac;
        it.dst_ip = tip;
        arp_pending.push_back(it);
    endtask

    task automatic queue_lookup(arpc_pkg::t_ip qip);
        t_arp_item it;
        it = noise_item();
        it.query_ip = qip;
        arp_pending.push_back(it);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_OWN_IP) begin
            own_ip_model = data[31:0];
        end else begin
            own_mac_model = data[47:0];
        end
    endtask

    task automatic wait_idle();
        while (arp_pending.size() != 0 || arp_req.valid || rsp_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arp_req.valid <= 1'b0;
        end else begin
            if (arp_req.valid && arp_req.ready) begin
                rsp_expected.push_back(resolve_arp_item(arp_current));
                items_accepted <= items_accepted + 1;
            end
            if (!arp_req.valid || arp_req.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    arp_req.valid <= 1'b0;
                end else if (arp_pending.size() != 0) begin
                    arp_current = arp_pending.pop_front();
                    arp_req.valid <= 1'b1;
                    arp_req.op <= arp_current.op;
                    arp_req.frame_length <= arp_current.frame_length;
                    arp_req.hardware_type <= arp_current.hardware_type;
                    arp_req.protocol_type <= arp_current.protocol_type;
                    arp_req.arp_opcode <= arp_current.arp_opcode;
                    arp_req.src_ip <= arp_current.src_ip;
                    arp_req.src_mac <= arp_current.src_mac;
                    arp_req.dst_ip <= arp_current.dst_ip;
                    arp_req.query_ip <= arp_current.query_ip;
                    send_gap = pick_gap(send_burst);
                end else begin
                    arp_req.valid <= 1'b0;
                end
            end
        end
    end

    // One long hold on the result side, so that the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arp_rsp.ready <= 1'b0;
        end else begin
            if (arp_rsp.valid && arp_rsp.ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: result item with none expected, status %0d", $time,
                             arp_rsp.status);
                    errors++;
                end else begin
                    rsp_want = rsp_expected.pop_front();
                    check_field("status", 64'(rsp_want.status), 64'(arp_rsp.status));
                    check_field("send_reply", 64'(rsp_want.send_reply),
                                64'(arp_rsp.send_reply));
                    check_field("reply_dest_mac", 64'(rsp_want.reply_dest_mac),
                                64'(arp_rsp.reply_dest_mac));
                    check_field("reply_dst_ip", 64'(rsp_want.reply_dst_ip),
                                64'(arp_rsp.reply_dst_ip));
                    check_field("reply_src_mac", 64'(rsp_want.reply_src_mac),
                                64'(arp_rsp.reply_src_mac));
                    check_field("reply_src_ip", 64'(rsp_want.reply_src_ip),
                                64'(arp_rsp.reply_src_ip));
                    check_field("found_mac", 64'(rsp_want.found_mac),
                                64'(arp_rsp.found_mac));
                end
            end
            if (hold_left > 0) begin
                arp_rsp.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                arp_rsp.ready <= 1'b0;
            end else begin
                arp_rsp.ready <= 1'b1;
                if ($urandom_range(3) == 0) begin
                    recv_stall = pick_gap(recv_burst);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("arp_responder_with_cache_tb failed");
        $finish;
    end

    initial begin
        arpc_pkg::t_ip  cfg_ip;
        arpc_pkg::t_mac cfg_mac;
        for (int i = 0; i < IP_POOL_SIZE; i++) begin
            ip_pool[i] = $urandom;
        end
        arp_req.valid = 1'b0;
        arp_req.op = OP_PACKET;
        arp_req.frame_length = '0;
        arp_req.hardware_type = '0;
        arp_req.protocol_type = '0;
        arp_req.arp_opcode = '0;
        arp_req.src_ip = '0;
        arp_req.src_mac = '0;
        arp_req.dst_ip = '0;
        arp_req.query_ip = '0;
        arp_rsp.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_lookup(32'h0000_0000);
        queue_packet(11'd0, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     arpc_pkg::OPC_REQUEST, 32'h0A00_0001, 48'h0200_0000_0001,
                     arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd27, 16'h0000, 16'h0000, arpc_pkg::OPC_REQUEST, 32'h0A00_0001,
                     48'h0200_0000_0001, arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd28, 16'h0000, arpc_pkg::PROTO_IPV4, arpc_pkg::OPC_REQUEST,
                     32'h0A00_0001, 48'h0200_0000_0001, arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd2047, 16'hFFFF, 16'h0000, arpc_pkg::OPC_REQUEST, 32'h0A00_0001,
                     48'h0200_0000_0001, arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, 16'h0000, arpc_pkg::OPC_REQUEST,
                     32'h0A00_0001, 48'h0200_0000_0001, arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd2047, arpc_pkg::HW_ETHERNET, 16'hFFFF, arpc_pkg::OPC_REQUEST,
                     32'h0A00_0001, 48'h0200_0000_0001, arpc_pkg::OWN_IP_RESET);
        queue_lookup(32'h0A00_0001);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     arpc_pkg::OPC_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                     arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd2047, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     arpc_pkg::OPC_REQUEST, 32'h0000_0000, 48'h0000_0000_0000,
                     arpc_pkg::OWN_IP_RESET ^ 32'h1);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     arpc_pkg::OPC_REPLY, 32'hC0A8_0001, 48'h0A0B_0C0D_0E0F,
                     arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'h0000,
                     32'hC0A8_0002, 48'h1111_2222_3333, arpc_pkg::OWN_IP_RESET);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4, 16'hFFFF,
                     32'hC0A8_0003, 48'h4444_5555_6666, 32'hFFFF_FFFF);
        queue_packet(11'd28, arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                     arpc_pkg::OPC_REQUEST, 32'hFFFF_FFFF, 48'h0123_4567_89AB,
                     arpc_pkg::OWN_IP_RESET);
        queue_lookup(32'hFFFF_FFFF);
        queue_lookup(32'h0000_0000);
        queue_lookup(32'hC0A8_0003);
        queue_lookup(32'h0A00_0001);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: begin
                    cfg_ip = '0;
                    cfg_mac = '1;
                end
                2: begin
                    cfg_ip = '1;
                    cfg_mac = '0;
                end
                default: begin
                    cfg_ip = $urandom;
                    cfg_mac = rand_mac();
                end
            endcase
            write_reg(ADDR_OWN_IP, {32'h0, cfg_ip});
            write_reg(ADDR_OWN_MAC, {16'h0, cfg_mac});
            repeat (RANDOM_ITEMS / PHASES) arp_pending.push_back(random_arp_item());
            wait_idle();
        end

        if (errors == 0) begin
            $display("arp_responder_with_cache_tb passed");
        end else begin
            $display("arp_responder_with_cache_tb failed");
        end
        $finish;
    end
endmodule

// File: sim.f
design/arpc_pkg.sv
design/arpc_if.sv
design/arpc_cell.sv
design/arp_responder_with_cache.sv
design/arpc_checker.sv
bench/arp_responder_with_cache_tb.sv
